/* src/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg - voice allocator shared definitions
// Event opcodes and result action codes for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] action_t;
  typedef logic [6:0] note_t;

  // event opcodes
  localparam op_t OP_NOTE_ON    = 2'd0;
  localparam op_t OP_NOTE_OFF   = 2'd1;
  localparam op_t OP_VOICE_DONE = 2'd2;
  localparam op_t OP_CLEAR_ALL  = 2'd3;

  // result actions
  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_START   = 2'd1;
  localparam action_t ACT_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic CFG_VOICE_COUNT = 1'b0;
  localparam logic CFG_KEY_SYNC    = 1'b1;

  localparam logic [4:0] VOICE_COUNT_RST = 5'd8;

endpackage

/* src/polyphonic_voice_allocator.sv */
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator - lowest free slot allocation, round-robin stealing
// Turns note events into voice start / release actions over a bank of slots.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_*): one note event per transfer (note on, note off,
//   voice done, clear all). Note on with zero velocity is a note off.
//   Result channel (out_*): exactly one result per event, in order, with the
//   slot mask as it stands after the event (released, silent slots dropped).
//   Config channel (cfg_*): voice count and key sync enable; always ready,
//   write only while no event is in flight.
// Sequencing (transfer to result valid)
//   Voice done, clear all: straight to commit. Note on/off: slots 0..n-1 (n =
//   voice count) are scanned behind a registered memory read; a match at slot
//   k ends the scan there. A note on with no match steals the cursor slot,
//   after one subtract of n a cycle while the cursor lies at or beyond the count.
//   One event at a time: the next is taken the cycle after its result loads.
// Reset / stall
//   Reset empties all slots, zeroes the steal cursor and loads voice count 8,
//   key sync off. No clearing pass: inactive slots never consult the memory.
//   A finished result waits in the output register; the next event is still
//   taken and held at commit until the register frees up.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator #(
  parameter int MAX_VOICES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // event input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pva_pkg::op_t         in_opcode,
  input  pva_pkg::note_t       in_note_number,
  input  logic [6:0]           in_note_velocity,
  input  logic [3:0]           in_done_voice,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output pva_pkg::action_t     out_action,
  output logic [3:0]           out_slot,
  output logic                 out_stolen,
  output logic                 out_sync_request,
  output logic [15:0]          out_active_mask,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data
);
  import pva_pkg::*;

  localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
  localparam int NMAX  = (MAX_VOICES > 31) ? 31 : MAX_VOICES;
  localparam logic [4:0] NMAX_C = 5'(NMAX);
  localparam int MASK_N = (MAX_VOICES < 16) ? MAX_VOICES : 16;

  // sequencer
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_MOD    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]            state_r, state_nxt;
  op_t                   op_r, op_nxt;
  note_t                 note_r, note_nxt;
  logic [3:0]            done_r, done_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic [IDX_W-1:0]      cursor_r, cursor_nxt;
  logic [MAX_VOICES-1:0] act_r, act_nxt;
  logic [MAX_VOICES-1:0] held_r, held_nxt;
  logic [MAX_VOICES-1:0] snd_r, snd_nxt;
  logic [4:0]            vc_r, vc_nxt;
  logic                  ksync_r, ksync_nxt;

  logic                  out_valid_r, out_valid_nxt;
  action_t               out_action_r, out_action_nxt;
  logic [3:0]            out_slot_r, out_slot_nxt;
  logic                  out_stolen_r, out_stolen_nxt;
  logic                  out_sync_r, out_sync_nxt;
  logic [15:0]           out_mask_r, out_mask_nxt;

  // note memory: one entry per slot, registered read.
  // Velocity is not stored; nothing reads it back.
  note_t                 note_mem [MAX_VOICES];
  note_t                 note_rd_r;
  logic                  mem_we;

  logic [4:0]            n_w;
  logic [CW-1:0]         n_cw;
  logic [CW-1:0]         cur_cw;
  logic                  rd_go;
  logic                  cmp_hit;
  logic                  scan_end;
  logic                  out_free;
  logic [IDX_W-1:0]      done_idx;
  logic [MAX_VOICES-1:0] a_w, h_w, s_w, a_clean;
  logic                  stolen_w;
  action_t               action_w;
  logic [15:0]           mask_w;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_slot         = out_slot_r;
  assign out_stolen       = out_stolen_r;
  assign out_sync_request = out_sync_r;
  assign out_active_mask  = out_mask_r;

  // slots in use: 0 counts as 1, capped at the bank size
  assign n_w = (vc_r == 5'd0) ? 5'd1 : ((vc_r > NMAX_C) ? NMAX_C : vc_r);
  assign n_cw   = CW'(n_w);
  assign cur_cw = CW'(cursor_r);

  assign rd_go    = (state_r == S_SCAN) && (rd_idx_r < n_cw);
  assign scan_end = !cmp_vld_r && (rd_idx_r >= n_cw);
  assign out_free = !out_valid_r || !out_stall;
  assign done_idx = IDX_W'(done_r);

  // compare stage sits in the cycle after the memory read
  always_comb begin
    if (op_r == OP_NOTE_ON) begin
      cmp_hit = cmp_vld_r && (!act_r[cmp_idx_r] || !snd_r[cmp_idx_r]);
    end else begin
      cmp_hit = cmp_vld_r && act_r[cmp_idx_r] && held_r[cmp_idx_r]
                && (note_rd_r == note_r);
    end
  end

  // slot update at commit, then drop released, silent slots
  always_comb begin
    a_w      = act_r;
    h_w      = held_r;
    s_w      = snd_r;
    stolen_w = 1'b0;
    action_w = ACT_NONE;
    case (op_r)
      OP_NOTE_ON: begin
        stolen_w     = snd_r[slot_r];
        a_w[slot_r]  = 1'b1;
        h_w[slot_r]  = 1'b1;
        s_w[slot_r]  = 1'b1;
        action_w     = ACT_START;
      end
      OP_NOTE_OFF: begin
        if (hit_r) begin
          h_w[slot_r] = 1'b0;
          action_w    = ACT_RELEASE;
        end
      end
      OP_VOICE_DONE: begin
        if (32'(done_r) < MAX_VOICES) begin
          s_w[done_idx] = 1'b0;
        end
      end
      default: begin
        a_w = '0;
        h_w = '0;
        s_w = '0;
      end
    endcase
    a_clean = a_w & (h_w | s_w);
    mask_w  = '0;
    for (int i = 0; i < MASK_N; i++) begin
      mask_w[i] = a_clean[i];
    end
  end

  assign mem_we = (state_r == S_COMMIT) && out_free && (op_r == OP_NOTE_ON);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    note_nxt       = note_r;
    done_nxt       = done_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    cursor_nxt     = cursor_r;
    act_nxt        = act_r;
    held_nxt       = held_r;
    snd_nxt        = snd_r;
    vc_nxt         = vc_r;
    ksync_nxt      = ksync_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_action_nxt = out_action_r;
    out_slot_nxt   = out_slot_r;
    out_stolen_nxt = out_stolen_r;
    out_sync_nxt   = out_sync_r;
    out_mask_nxt   = out_mask_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_VOICE_COUNT: vc_nxt    = cfg_data;
        CFG_KEY_SYNC:    ksync_nxt = cfg_data[0];
        default:         vc_nxt    = vc_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // zero velocity note on behaves as note off
          if (in_opcode == OP_NOTE_ON && in_note_velocity == 7'd0) begin
            op_nxt = OP_NOTE_OFF;
          end else begin
            op_nxt = in_opcode;
          end
          note_nxt    = in_note_number;
          done_nxt    = in_done_voice;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          slot_nxt    = '0;
          if (in_opcode == OP_NOTE_ON || in_opcode == OP_NOTE_OFF) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        cmp_vld_nxt = rd_go;
        if (rd_go) begin
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (cmp_hit) begin
          hit_nxt   = 1'b1;
          slot_nxt  = cmp_idx_r;
          state_nxt = S_COMMIT;
        end else if (scan_end) begin
          state_nxt = (op_r == OP_NOTE_ON) ? S_MOD : S_COMMIT;
        end
      end
      S_MOD: begin
        // cursor mod n by repeated subtract, then advance with wrap
        if (cur_cw >= n_cw) begin
          cursor_nxt = IDX_W'(cur_cw - n_cw);
        end else begin
          slot_nxt = cursor_r;
          if (cur_cw + CW'(1) == n_cw) begin
            cursor_nxt = '0;
          end else begin
            cursor_nxt = IDX_W'(cur_cw + CW'(1));
          end
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          act_nxt  = a_clean;
          held_nxt = h_w;
          snd_nxt  = s_w;
          if (op_r == OP_CLEAR_ALL) begin
            cursor_nxt = '0;
          end
          out_valid_nxt  = 1'b1;
          out_action_nxt = action_w;
          out_slot_nxt   = (action_w == ACT_NONE) ? 4'd0 : 4'(slot_r);
          out_stolen_nxt = stolen_w;
          out_sync_nxt   = (action_w == ACT_START) && ksync_r && !stolen_w;
          out_mask_nxt   = mask_w;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      cursor_r    <= '0;
      act_r       <= '0;
      held_r      <= '0;
      snd_r       <= '0;
      vc_r        <= VOICE_COUNT_RST;
      ksync_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cursor_r    <= cursor_nxt;
      act_r       <= act_nxt;
      held_r      <= held_nxt;
      snd_r       <= snd_nxt;
      vc_r        <= vc_nxt;
      ksync_r     <= ksync_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    note_r       <= note_nxt;
    done_r       <= done_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    slot_r       <= slot_nxt;
    out_action_r <= out_action_nxt;
    out_slot_r   <= out_slot_nxt;
    out_stolen_r <= out_stolen_nxt;
    out_sync_r   <= out_sync_nxt;
    out_mask_r   <= out_mask_nxt;
  end

  // note memory; writes only at commit, reads only while scanning,
  // so the two never meet in one cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[slot_r] <= note_r;
    end
    if (rd_go) begin
      note_rd_r <= note_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // checks
  a_held_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~act_r) == '0)
    else $error("held slot is not active");

  a_cleanup_done: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r & ~(held_r | snd_r)) == '0)
    else $error("released silent slot left active");

  a_idle_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r == ACT_NONE) |->
      (out_slot_r == 4'd0 && !out_stolen_r && !out_sync_r))
    else $error("empty result carries slot or flags");

  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not load result register");

  a_steal_no_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stolen_r) |-> !out_sync_r)
    else $error("sync requested on stolen voice");

endmodule
